// ===== src/overlapping_motif_position_finder_top_assert.svh =====
// ---------------------------------------------------------------------------
// overlapping motif position finder assertion macros
// shared concurrent assertion forms, sampled on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef OVERLAPPING_MOTIF_POSITION_FINDER_TOP_ASSERT_SVH
`define OVERLAPPING_MOTIF_POSITION_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define OMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/omp_pkg.sv =====
// ---------------------------------------------------------------------------
// omp_pkg
// shared widths, register indexes and config bundle of the motif finder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package omp_pkg;

    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int MOTIF_WORDS     = 4;
    localparam int CHARS_PER_WORD  = CFG_DATA_W / CHAR_W;
    localparam int MOTIF_CHARS     = MOTIF_WORDS * CHARS_PER_WORD;
    localparam int MOTIF_IDX_W     = $clog2(MOTIF_CHARS);
    localparam int MAX_MOTIF_DEF   = 32;
    localparam int POS_WIDTH_DEF   = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTIF_LENGTH  = 3'd0,
        REG_MOTIF_CHARS_0 = 3'd1,
        REG_MOTIF_CHARS_1 = 3'd2,
        REG_MOTIF_CHARS_2 = 3'd3,
        REG_MOTIF_CHARS_3 = 3'd4
    } omp_reg_idx_t;

    // motif setup seen by every cell
    typedef struct packed {
        logic [LEN_W-1:0]                        len;
        logic [MOTIF_CHARS-1:0][CHAR_W-1:0]      motif;
    } omp_cfg_t;

endpackage

// ===== src/overlapping_motif_position_finder_top.sv =====
// ---------------------------------------------------------------------------
// overlapping_motif_position_finder_top
// exact motif search over a character stream, all overlapping occurrences
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid / in_ready     | seq_char, seq_last
//  out     | out_valid / out_ready   | match_found, start_position, sequence_end
//  cfg     | cfg_wr_en               | cfg_index, cfg_data
//
//  one character per cycle while in_ready is high; a request's result is
//  registered into the output register, or into the skid entry if that is full
//  the comparison is a row of MAX_MOTIF cells evaluated in parallel, each
//  checking one window position against its motif character
//  an output register plus one skid entry: input stalls only when both hold
//  a waiting result
//  reset clears position count, output state and motif setup; the history
//  chain needs no clearing since it is read only after a full window

module overlapping_motif_position_finder_top #(
    parameter int MAX_MOTIF      = omp_pkg::MAX_MOTIF_DEF,
    parameter int POSITION_WIDTH = omp_pkg::POS_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [omp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [omp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // character requests
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [omp_pkg::CHAR_W-1:0]      seq_char,
    input  logic                            seq_last,
    // results
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            match_found,
    output logic [POSITION_WIDTH-1:0]       start_position,
    output logic                            sequence_end
);
    import omp_pkg::*;

    typedef struct packed {
        logic                      match;
        logic [POSITION_WIDTH-1:0] start;
        logic                      last;
    } omp_res_t;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    // configuration registers
    logic [LEN_W-1:0]                       len_reg;
    logic [MOTIF_WORDS-1:0][CFG_DATA_W-1:0] words_reg;
    omp_cfg_t                               cfg;
    logic [LEN_W-1:0]                       len_eff;
    logic [LEN_W-1:0]                       len_m1;

    // cell chain
    logic [CHAR_W-1:0] chain [MAX_MOTIF+1];
    logic [MAX_MOTIF-1:0] hits;

    // position and result path
    logic [POSITION_WIDTH-1:0] chars_seen_reg;
    logic [POSITION_WIDTH-1:0] chars_seen_next;
    logic                      in_fire;
    logic                      window_full;
    logic                      is_match;
    logic                      has_result;
    omp_res_t                  new_res;

    // output register and skid entry
    omp_res_t out_reg;
    omp_res_t out_next;
    omp_res_t skid_reg;
    omp_res_t skid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    logic     pop;
    logic     push;

    // -----------------------------------------------------------------------
    // configuration writes
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            words_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MOTIF_LENGTH:  len_reg      <= cfg_data[LEN_W-1:0];
                REG_MOTIF_CHARS_0: words_reg[0] <= cfg_data;
                REG_MOTIF_CHARS_1: words_reg[1] <= cfg_data;
                REG_MOTIF_CHARS_2: words_reg[2] <= cfg_data;
                REG_MOTIF_CHARS_3: words_reg[3] <= cfg_data;
                default:           ;   // indexes past the list are dropped
            endcase
        end
    end

    // zero length acts as one, anything past the cell count is clamped
    always_comb
    begin
        if (len_reg == '0)
            len_eff = LEN_W'(1);
        else if (len_reg > LEN_W'(MAX_MOTIF))
            len_eff = LEN_W'(MAX_MOTIF);
        else
            len_eff = len_reg;
    end

    assign len_m1    = len_eff - LEN_W'(1);
    assign cfg.len   = len_eff;
    assign cfg.motif = words_reg;

    // -----------------------------------------------------------------------
    // comparison chain: cell 0 sees the newest character, cell k the one
    // k positions back; every accepted request shifts the chain by one
    // -----------------------------------------------------------------------
    assign chain[0] = seq_char;

    for (genvar k = 0; k < MAX_MOTIF; k++)
    begin : g_cell
        omp_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk      (clk),
            .shift_en (in_fire),
            .char_in  (chain[k]),
            .char_out (chain[k+1]),
            .cfg      (cfg),
            .hit      (hits[k])
        );
    end

    // -----------------------------------------------------------------------
    // match decision and position counter
    // -----------------------------------------------------------------------
    assign in_ready    = !skid_valid_reg;
    assign in_fire     = in_valid && in_ready;

    // history only trusted after len-1 characters of this sequence
    assign window_full = chars_seen_reg >= POSITION_WIDTH'(len_m1);
    assign is_match    = window_full && (&hits);
    assign has_result  = is_match || seq_last;

    assign new_res.match = is_match;
    assign new_res.start = is_match ? (chars_seen_reg - POSITION_WIDTH'(len_m1)) : '0;
    assign new_res.last  = seq_last;

    always_comb
    begin
        chars_seen_next = chars_seen_reg;
        if (in_fire)
        begin
            if (seq_last)
                chars_seen_next = '0;
            else if (chars_seen_reg != POS_MAX)
                chars_seen_next = chars_seen_reg + POSITION_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chars_seen_reg <= '0;
        else
            chars_seen_reg <= chars_seen_next;
    end

    // -----------------------------------------------------------------------
    // output register with skid entry
    // -----------------------------------------------------------------------
    assign pop  = out_valid_reg && out_ready;
    assign push = in_fire && has_result;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // input is stalled here, only draining happens
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = new_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = new_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign match_found    = out_reg.match;
    assign start_position = out_reg.start;
    assign sequence_end   = out_reg.last;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    `include "overlapping_motif_position_finder_top_assert.svh"

    `OMP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry holds a result while the output register is empty")
    `OMP_ASSERT_NOW(a_result_not_empty, out_valid_reg, out_reg.match || out_reg.last,
        "result with neither match nor sequence end")
    `OMP_ASSERT_NOW(a_start_zero_no_match, out_valid_reg && !out_reg.match,
        out_reg.start == '0, "start position set without a match")
    `OMP_ASSERT_NEXT(a_restart_after_last, in_fire && seq_last, chars_seen_reg == '0,
        "position count not restarted after the final character")

endmodule

// ===== src/omp_cell.sv =====
// ---------------------------------------------------------------------------
// omp_cell
// one window position: compares its character and passes it down the chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module omp_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                         clk,
    input  logic                         shift_en,
    input  logic [omp_pkg::CHAR_W-1:0]   char_in,
    output logic [omp_pkg::CHAR_W-1:0]   char_out,
    input  omp_pkg::omp_cfg_t            cfg,
    output logic                         hit
);
    import omp_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic [LEN_W-1:0]  motif_idx;
    logic [CHAR_W-1:0] expected;
    logic              in_use;

    // cell k checks motif character len-1-k
    assign in_use    = LEN_W'(CELL_IDX) < cfg.len;
    assign motif_idx = cfg.len - LEN_W'(CELL_IDX) - LEN_W'(1);
    assign expected  = cfg.motif[motif_idx[MOTIF_IDX_W-1:0]];
    assign hit       = !in_use || (char_in == expected);

    assign char_next = shift_en ? char_in : char_reg;
    assign char_out  = char_reg;

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

endmodule
